@@ hdl/bpa_pkg.sv @@
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types for the buddy page allocator: controller states, datapath
// commands and the status bundle returned to the controller.
// ----------------------------------------------------------------------------
package bpa_pkg;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_ASCAN,
		ST_USTART,
		ST_UHEAD,
		ST_UTAIL,
		ST_UMID,
		ST_MSTEP,
		ST_TRD,
		ST_TWR,
		ST_SPLIT,
		ST_APPEND,
		ST_RESULT
	} bpa_state_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_CLR,
		DP_LOAD,
		DP_SCAN_INC,
		DP_PICK,
		DP_U_CLEARV,
		DP_U_RD,
		DP_U_HEAD,
		DP_U_TAIL,
		DP_U_MID,
		DP_MERGE_STEP,
		DP_T_RD,
		DP_T_WR,
		DP_SPLIT,
		DP_APPEND,
		DP_RESULT
	} bpa_op_t;

	typedef struct packed {
		bpa_op_t op;
	} bpa_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic op_free;
		logic order_bad;
		logic scan_end;
		logic cur_valid;
		logic x_is_head;
		logic x_is_tail;
		logic tog_old;
		logic n_eq_order;
		logic n_is_top;
		logic out_free;
	} bpa_status_t;

endpackage

@@ hdl/bpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer for alloc and free requests: scan, split, merge, unlink and
// append steps, plus the toggle-bit clearing pass after reset.
// ----------------------------------------------------------------------------
module bpa_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  bpa_pkg::bpa_status_t st,
	output bpa_pkg::bpa_cmd_t    cmd
);
	import bpa_pkg::*;

	bpa_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// after an unlink, a free merges and an alloc toggles
	function automatic bpa_state_t after_unlink(input logic is_free);
		after_unlink = is_free ? ST_MSTEP : ST_TRD;
	endfunction

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (st.clear_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				if (st.order_bad) state_d = ST_RESULT;
				else if (st.op_free) state_d = ST_TRD;
				else state_d = ST_ASCAN;
			end
			ST_ASCAN: begin
				if (st.scan_end) state_d = ST_RESULT;
				else if (st.cur_valid) state_d = ST_USTART;
			end
			ST_USTART: begin
				if (!st.cur_valid || (st.x_is_head && st.x_is_tail))
					state_d = after_unlink(st.op_free);
				else if (st.x_is_head) state_d = ST_UHEAD;
				else if (st.x_is_tail) state_d = ST_UTAIL;
				else state_d = ST_UMID;
			end
			ST_UHEAD, ST_UTAIL, ST_UMID: begin
				state_d = after_unlink(st.op_free);
			end
			ST_MSTEP: begin
				state_d = ST_TRD;
			end
			ST_TRD: begin
				state_d = ST_TWR;
			end
			ST_TWR: begin
				if (st.op_free) begin
					if (!st.tog_old || st.n_is_top) state_d = ST_APPEND;
					else state_d = ST_USTART;
				end else begin
					state_d = st.n_eq_order ? ST_RESULT : ST_SPLIT;
				end
			end
			ST_SPLIT: begin
				state_d = ST_TRD;
			end
			ST_APPEND: begin
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (st.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// command outputs
	always_comb begin
		cmd.op = DP_NOP;
		case (state_q)
			ST_CLEAR: if (!st.clear_done) cmd.op = DP_CLR;
			ST_IDLE: if (in_valid) cmd.op = DP_LOAD;
			ST_ASCAN: begin
				if (!st.scan_end) cmd.op = st.cur_valid ? DP_PICK : DP_SCAN_INC;
			end
			ST_USTART: begin
				if (st.cur_valid) begin
					if (st.x_is_head && st.x_is_tail) cmd.op = DP_U_CLEARV;
					else cmd.op = DP_U_RD;
				end
			end
			ST_UHEAD: cmd.op = DP_U_HEAD;
			ST_UTAIL: cmd.op = DP_U_TAIL;
			ST_UMID: cmd.op = DP_U_MID;
			ST_MSTEP: cmd.op = DP_MERGE_STEP;
			ST_TRD: cmd.op = DP_T_RD;
			ST_TWR: cmd.op = DP_T_WR;
			ST_SPLIT: cmd.op = DP_SPLIT;
			ST_APPEND: cmd.op = DP_APPEND;
			ST_RESULT: if (st.out_free) cmd.op = DP_RESULT;
			default: cmd.op = DP_NOP;
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

@@ hdl/bpa_datapath.sv @@
// ----------------------------------------------------------------------------
// bpa_datapath
// Link memories, pair toggle memory, per-order list ends, work registers
// and the output register of the buddy page allocator.
// ----------------------------------------------------------------------------
module bpa_datapath #(
	parameter int NUM_ORDERS      = 11,
	parameter int PAGE_INDEX_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bpa_pkg::bpa_cmd_t    cmd,
	output bpa_pkg::bpa_status_t st,
	input  logic                 opcode,
	input  logic [3:0]           block_order,
	input  logic [15:0]          free_pfn,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [15:0]          result_pfn,
	output logic                 ok
);
	import bpa_pkg::*;

	localparam int P  = PAGE_INDEX_BITS;
	localparam int OB = $clog2(NUM_ORDERS);
	localparam int OW = $clog2(NUM_ORDERS + 1);
	localparam int TW = OB + P - 1;

	// memories
	logic [P-1:0] next_mem [2**P];
	logic [P-1:0] prev_mem [2**P];
	logic         tog_mem  [2**TW];

	// list ends
	logic [P-1:0]          head_q [NUM_ORDERS];
	logic [P-1:0]          tail_q [NUM_ORDERS];
	logic [NUM_ORDERS-1:0] valid_q;

	// work registers
	logic          op_q, bad_q;
	logic [3:0]    ord_q;
	logic [OW-1:0] n_q;
	logic [P-1:0]  page_q, x_q;
	logic [P-1:0]  nrd_q, prd_q;
	logic          tog_rd_q;
	logic [15:0]   res_pfn_q;
	logic          res_ok_q;
	logic [TW:0]   clr_q;
	logic          out_valid_q;
	logic [15:0]   out_pfn_q;
	logic          out_ok_q;

	logic [OB-1:0] nidx, nm1idx;
	logic [OW-1:0] n_m1;
	logic [P-1:0]  pfn_in, align_mask, page_sh, bit_n, bit_m1;
	logic [TW-1:0] tog_addr;
	logic          order_bad;

	assign nidx   = n_q[OB-1:0];
	assign n_m1   = n_q - OW'(1);
	assign nm1idx = n_m1[OB-1:0];
	assign bit_n  = P'(1) << n_q;
	assign bit_m1 = P'(1) << n_m1;

	// incoming page, masked and aligned
	assign pfn_in     = P'(free_pfn);
	assign align_mask = ~((P'(1) << block_order) - P'(1));
	assign order_bad  = ({1'b0, block_order} >= 5'(NUM_ORDERS));

	// pair bit address: order and pfn >> (order + 1)
	assign page_sh  = page_q >> n_q;
	assign tog_addr = {nidx, page_sh[P-1:1]};

	// append target: split appends to the lower order
	logic          ap_en;
	logic [OB-1:0] ap_idx;
	logic [P-1:0]  ap_val;
	always_comb begin
		ap_en  = (cmd.op == DP_SPLIT) || (cmd.op == DP_APPEND);
		ap_idx = (cmd.op == DP_SPLIT) ? nm1idx : nidx;
		ap_val = (cmd.op == DP_SPLIT) ? (page_q + bit_m1) : page_q;
	end

	// link write ports
	logic         nw_en, pw_en;
	logic [P-1:0] nw_addr, nw_data, pw_addr, pw_data;
	always_comb begin
		nw_en   = 1'b0;
		pw_en   = 1'b0;
		nw_addr = tail_q[ap_idx];
		nw_data = ap_val;
		pw_addr = ap_val;
		pw_data = tail_q[ap_idx];
		if (ap_en && valid_q[ap_idx]) begin
			nw_en = 1'b1;
			pw_en = 1'b1;
		end else if (cmd.op == DP_U_MID) begin
			nw_en   = 1'b1;
			pw_en   = 1'b1;
			nw_addr = prd_q;
			nw_data = nrd_q;
			pw_addr = nrd_q;
			pw_data = prd_q;
		end
	end

	// link memories
	always_ff @(posedge clk) begin
		if (nw_en) next_mem[nw_addr] <= nw_data;
		if (pw_en) prev_mem[pw_addr] <= pw_data;
		if (cmd.op == DP_U_RD) begin
			nrd_q <= next_mem[x_q];
			prd_q <= prev_mem[x_q];
		end
	end

	// toggle memory: clearing pass, read, inverted write-back
	always_ff @(posedge clk) begin
		if (cmd.op == DP_CLR) tog_mem[clr_q[TW-1:0]] <= 1'b0;
		else if (cmd.op == DP_T_WR) tog_mem[tog_addr] <= ~tog_rd_q;
		if (cmd.op == DP_T_RD) tog_rd_q <= tog_mem[tog_addr];
	end

	// clear counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.op == DP_CLR) begin
			clr_q <= clr_q + (TW+1)'(1);
		end
	end

	// list valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ap_en) begin
			valid_q[ap_idx] <= 1'b1;
		end else if (cmd.op == DP_U_CLEARV) begin
			valid_q[nidx] <= 1'b0;
		end
	end

	// list ends
	always_ff @(posedge clk) begin
		if (ap_en) begin
			tail_q[ap_idx] <= ap_val;
			if (!valid_q[ap_idx]) head_q[ap_idx] <= ap_val;
		end
		if (cmd.op == DP_U_HEAD) head_q[nidx] <= nrd_q;
		if (cmd.op == DP_U_TAIL) tail_q[nidx] <= prd_q;
	end

	// work registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LOAD: begin
				op_q  <= opcode;
				ord_q <= block_order;
				bad_q <= order_bad;
				n_q   <= OW'(block_order);
				page_q <= pfn_in & align_mask;
				if (!opcode) begin
					res_pfn_q <= '0;
					res_ok_q  <= 1'b0;
				end else if (order_bad) begin
					res_pfn_q <= 16'(pfn_in);
					res_ok_q  <= 1'b0;
				end else begin
					res_pfn_q <= 16'(pfn_in & align_mask);
					res_ok_q  <= 1'b1;
				end
			end
			DP_SCAN_INC: n_q <= n_q + OW'(1);
			DP_PICK: begin
				page_q    <= head_q[nidx];
				x_q       <= head_q[nidx];
				res_pfn_q <= 16'(head_q[nidx]);
				res_ok_q  <= 1'b1;
			end
			DP_T_WR: x_q <= page_q ^ bit_n;
			DP_MERGE_STEP: begin
				page_q <= page_q & ~bit_n;
				n_q    <= n_q + OW'(1);
			end
			DP_SPLIT: n_q <= n_m1;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == DP_RESULT) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == DP_RESULT) begin
			out_pfn_q <= res_pfn_q;
			out_ok_q  <= res_ok_q;
		end
	end

	// status back to the controller
	always_comb begin
		st.clear_done = clr_q[TW];
		st.op_free    = op_q;
		st.order_bad  = bad_q;
		st.scan_end   = (n_q >= OW'(NUM_ORDERS));
		st.cur_valid  = !st.scan_end && valid_q[nidx];
		st.x_is_head  = (x_q == head_q[nidx]);
		st.x_is_tail  = (x_q == tail_q[nidx]);
		st.tog_old    = tog_rd_q;
		st.n_eq_order = (n_q == OW'(ord_q));
		st.n_is_top   = (n_q == OW'(NUM_ORDERS - 1));
		st.out_free   = !out_valid_q || !out_stall;
	end

	assign out_valid  = out_valid_q;
	assign result_pfn = out_pfn_q;
	assign ok         = out_ok_q;

endmodule

@@ hdl/buddy_page_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// buddy_page_allocator_unit
// Buddy page allocator: per-order FIFO free lists and pair toggle bits.
// ----------------------------------------------------------------------------
// Alloc scans upward from the requested order, unlinks the head block and
//   splits it down to that order; free merges with free buddies, then appends.
// Throughput: one request at a time, the next accepted the cycle after the
//   result is loaded; each split or merge step is a toggle read-modify-write.
// Reset: lists empty at once; then a clearing pass zeroes all 2^(clog2(NUM_ORDERS) +
//   PAGE_INDEX_BITS - 1) toggle bits before requests are taken.
module buddy_page_allocator_unit #(
	parameter int NUM_ORDERS      = 11,
	parameter int PAGE_INDEX_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [3:0]  block_order,
	input  logic [15:0] free_pfn,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] result_pfn,
	output logic        ok
);
	import bpa_pkg::*;

	bpa_cmd_t    cmd;
	bpa_status_t st;

	bpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	bpa_datapath #(
		.NUM_ORDERS      (NUM_ORDERS),
		.PAGE_INDEX_BITS (PAGE_INDEX_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.opcode      (opcode),
		.block_order (block_order),
		.free_pfn    (free_pfn),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_pfn  (result_pfn),
		.ok          (ok)
	);

	// an accepted request holds off the next one
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted while busy");

	// no request is taken during the clearing pass
	a_clear_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == DP_CLR |-> in_stall)
		else $error("request port open during clear");

	// a finished request shows up on the output
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == DP_RESULT |=> out_valid)
		else $error("result not presented");

endmodule
